FILE: rtl/linear_sieve_multiplicative_tables_defines.svh
// assertion macros for the linear sieve engine
`ifndef LINEAR_SIEVE_MULTIPLICATIVE_TABLES_DEFINES_SVH
`define LINEAR_SIEVE_MULTIPLICATIVE_TABLES_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSMT_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication, checked outside reset
`define LSMT_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

FILE: rtl/lsmt_pkg.sv
// shared types and constants of the linear sieve engine
package lsmt_pkg;
	localparam int TABLE_DEPTH = 65536;
	localparam int TABLE_AW = 16;
	localparam int PRIME_LIST_DEPTH = 8192;
	localparam int PRIME_AW = 13;
	localparam int BOUND_W = 17;
	localparam int COUNT_W = PRIME_AW + 1;
	localparam logic [BOUND_W-1:0] RANGE_EXTRA = 17'd10;
	localparam logic [15:0] LIMIT_RESET = 16'd65526;
	localparam logic signed [1:0] MOB_NEG = -2'sd1;
	localparam logic signed [1:0] MOB_POS = 2'sd1;

	typedef struct packed {
		logic [15:0] fac;
		logic signed [1:0] mob;
		logic [15:0] tot;
		logic [4:0] expo;
		logic [15:0] pp;
		logic [21:0] dsum;
		logic [15:0] rest;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [4:0] {
		OP_NONE,
		OP_QUERY_START,
		OP_QUERY_LOAD,
		OP_BUILD_START,
		OP_CLEAR,
		OP_SIEVE_INIT,
		OP_FINISH,
		OP_OUT_RD,
		OP_OUT_CHK,
		OP_IN_RD,
		OP_IN_U,
		OP_IN_MUL,
		OP_IN_M1,
		OP_IN_WRN,
		OP_IN_PP,
		OP_IN_DS,
		OP_IN_WRD,
		OP_NEXT_I
	} op_t;

	typedef struct packed {
		op_t op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic clear_last;
		logic i_end;
		logic k_end;
		logic prod_ge;
		logic div;
	} status_t;
endpackage

FILE: rtl/lsmt_in_if.sv
// input channel of the sieve engine
interface lsmt_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [15:0] query_value;

	modport source (output valid, output kind, output query_value, input ready);
	modport sink (input valid, input kind, input query_value, output ready);
endinterface

FILE: rtl/lsmt_out_if.sv
// result channel of the sieve engine
interface lsmt_out_if;
	logic valid;
	logic ready;
	logic in_range;
	logic [15:0] least_factor;
	logic signed [1:0] mobius;
	logic [15:0] totient;
	logic [4:0] least_exponent;
	logic [15:0] least_prime_power;
	logic [21:0] divisor_sum;

	modport source (output valid, output in_range, output least_factor, output mobius,
		output totient, output least_exponent, output least_prime_power,
		output divisor_sum, input ready);
	modport sink (input valid, input in_range, input least_factor, input mobius,
		input totient, input least_exponent, input least_prime_power,
		input divisor_sum, output ready);
endinterface

FILE: rtl/linear_sieve_multiplicative_tables.sv
// query: the entry is read into the ram output register, then loaded into the result registers
// once the output is free; no new item is taken until that load. build: clears entries 0 to n+9
// (at most 65536), then walks the known primes from each integer; a build gives no result
// reset clears the sequencer, prime count and built range, and sets the limit to 65526;
// queries before the first build return in_range 0 and zeros
module linear_sieve_multiplicative_tables import lsmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lsmt_in_if.sink     items,
	lsmt_out_if.source  results,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata
);
`include "linear_sieve_multiplicative_tables_defines.svh"

	cmd_t cmd;
	status_t st;

	lsmt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(items.valid), .in_kind(items.kind),
		.st(st), .cmd(cmd)
	);

	lsmt_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.query_value(items.query_value), .out_ready(results.ready), .st(st),
		.out_valid(results.valid), .in_range(results.in_range),
		.least_factor(results.least_factor), .mobius(results.mobius),
		.totient(results.totient), .least_exponent(results.least_exponent),
		.least_prime_power(results.least_prime_power), .divisor_sum(results.divisor_sum)
	);

	assign items.ready = cmd.in_ready;

	`LSMT_ASSERT_NEXT(a_build_busy, items.valid && items.ready && !items.kind, !items.ready, "input taken during build")
	`LSMT_ASSERT_NOW(a_no_overwrite, cmd.op == OP_QUERY_LOAD, !results.valid || results.ready, "pending result overwritten")
	`LSMT_ASSERT_NOW(a_out_range_zero, results.valid && !results.in_range, results.least_factor == 16'd0 && results.divisor_sum == 22'd0, "out of range result not zero")
endmodule

FILE: rtl/lsmt_ram.sv
// generic single write port ram with registered read
module lsmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/lsmt_ctrl.sv
// sequencer of the sieve engine
module lsmt_ctrl import lsmt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_kind,
	input  status_t st,
	output cmd_t    cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_QHOLD, S_CLEAR, S_INIT, S_TOP, S_CHK, S_IRD, S_IU, S_IMUL,
		S_ICHK, S_M2N, S_M2D, S_M3D, S_WRD
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind) begin
						cmd.op = OP_QUERY_START;
						state_d = S_QHOLD;
					end else begin
						cmd.op = OP_BUILD_START;
						state_d = S_CLEAR;
					end
				end
			end
			S_QHOLD: begin
				if (st.out_free) begin
					cmd.op = OP_QUERY_LOAD;
					state_d = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clear_last) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.op = OP_SIEVE_INIT;
				state_d = S_TOP;
			end
			S_TOP: begin
				if (st.i_end) begin
					cmd.op = OP_FINISH;
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_OUT_RD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.op = OP_OUT_CHK;
				state_d = S_IRD;
			end
			S_IRD: begin
				if (st.k_end) begin
					cmd.op = OP_NEXT_I;
					state_d = S_TOP;
				end else begin
					cmd.op = OP_IN_RD;
					state_d = S_IU;
				end
			end
			S_IU: begin
				cmd.op = OP_IN_U;
				state_d = S_IMUL;
			end
			S_IMUL: begin
				cmd.op = OP_IN_MUL;
				state_d = S_ICHK;
			end
			S_ICHK: begin
				if (st.prod_ge) begin
					cmd.op = OP_NEXT_I;
					state_d = S_TOP;
				end else begin
					cmd.op = OP_IN_M1;
					state_d = st.div ? S_M2D : S_M2N;
				end
			end
			S_M2N: begin
				cmd.op = OP_IN_WRN;
				state_d = S_IRD;
			end
			S_M2D: begin
				cmd.op = OP_IN_PP;
				state_d = S_M3D;
			end
			S_M3D: begin
				cmd.op = OP_IN_DS;
				state_d = S_WRD;
			end
			S_WRD: begin
				cmd.op = OP_IN_WRD;
				state_d = S_TOP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/lsmt_dpath.sv
// tables, prime list and arithmetic of the sieve engine
module lsmt_dpath import lsmt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              cfg_wen,
	input  logic [15:0]       cfg_wdata,
	input  logic [15:0]       query_value,
	input  logic              out_ready,
	output status_t           st,
	output logic              out_valid,
	output logic              in_range,
	output logic [15:0]       least_factor,
	output logic signed [1:0] mobius,
	output logic [15:0]       totient,
	output logic [4:0]        least_exponent,
	output logic [15:0]       least_prime_power,
	output logic [21:0]       divisor_sum
);
	logic [15:0] limit_q;
	logic [BOUND_W-1:0] bound_q, built_q, i_q, bound_sum;
	logic [COUNT_W-1:0] k_q, count_q;
	entry_t ent_q;
	logic [15:0] u_q, tot_q, pp_q;
	logic [31:0] prod_q;
	logic [21:0] dsum_q;
	logic qin_q;

	logic t_we, t_re;
	logic [TABLE_AW-1:0] t_waddr, t_raddr;
	entry_t t_wdata, t_rdata, prime_ent, one_ent;
	logic p_we, p_re;
	logic [PRIME_AW-1:0] p_waddr, p_raddr;
	logic [15:0] p_wdata, p_rdata;
	logic div;

	lsmt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(t_raddr), .rdata(t_rdata)
	);

	lsmt_ram #(.WIDTH(16), .DEPTH(PRIME_LIST_DEPTH)) u_primes (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata)
	);

	assign bound_sum = {1'b0, limit_q} + RANGE_EXTRA;
	// for primes up to the least factor, divisibility means equal to it
	assign div = (u_q == ent_q.fac);

	always_comb begin
		one_ent = '0;
		one_ent.mob = MOB_POS;
		one_ent.tot = 16'd1;
		one_ent.dsum = 22'd1;
		prime_ent.fac = i_q[15:0];
		prime_ent.mob = MOB_NEG;
		prime_ent.tot = i_q[15:0] - 16'd1;
		prime_ent.expo = 5'd1;
		prime_ent.pp = i_q[15:0];
		prime_ent.dsum = 22'(i_q) + 22'd1;
		prime_ent.rest = 16'd1;
	end

	always_comb begin
		t_we = 1'b0;
		t_re = 1'b0;
		t_waddr = prod_q[TABLE_AW-1:0];
		t_raddr = i_q[TABLE_AW-1:0];
		t_wdata = '0;
		p_we = 1'b0;
		p_re = 1'b0;
		p_waddr = count_q[PRIME_AW-1:0];
		p_raddr = k_q[PRIME_AW-1:0];
		p_wdata = i_q[15:0];
		case (cmd.op)
			OP_QUERY_START: begin
				t_re = 1'b1;
				t_raddr = query_value;
			end
			OP_CLEAR: begin
				t_we = 1'b1;
				t_waddr = i_q[TABLE_AW-1:0];
				t_wdata = (i_q == BOUND_W'(1)) ? one_ent : '0;
			end
			OP_OUT_RD: begin
				t_re = 1'b1;
			end
			OP_OUT_CHK: begin
				if (t_rdata.fac == 16'd0) begin
					t_we = 1'b1;
					t_waddr = i_q[TABLE_AW-1:0];
					t_wdata = prime_ent;
					p_we = (count_q < COUNT_W'(PRIME_LIST_DEPTH));
				end
			end
			OP_IN_RD: begin
				p_re = 1'b1;
			end
			OP_IN_WRN: begin
				t_we = 1'b1;
				t_wdata.fac = u_q;
				t_wdata.mob = -ent_q.mob;
				t_wdata.tot = tot_q;
				t_wdata.expo = 5'd1;
				t_wdata.pp = u_q;
				t_wdata.dsum = 22'(ent_q.dsum * ({1'b0, u_q} + 17'd1));
				t_wdata.rest = i_q[15:0];
			end
			OP_IN_PP: begin
				t_re = 1'b1;
				t_raddr = ent_q.rest;
			end
			OP_IN_WRD: begin
				t_we = 1'b1;
				t_wdata.fac = u_q;
				t_wdata.mob = 2'sd0;
				t_wdata.tot = tot_q;
				t_wdata.expo = ent_q.expo + 5'd1;
				t_wdata.pp = pp_q;
				t_wdata.dsum = dsum_q + ent_q.dsum;
				t_wdata.rest = ent_q.rest;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			bound_q <= '0;
			built_q <= '0;
			i_q <= '0;
			k_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wen) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.op == OP_QUERY_LOAD) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (cmd.op)
				OP_BUILD_START: begin
					bound_q <= (bound_sum > BOUND_W'(TABLE_DEPTH)) ?
						BOUND_W'(TABLE_DEPTH) : bound_sum;
					i_q <= '0;
					count_q <= '0;
				end
				OP_CLEAR: i_q <= i_q + BOUND_W'(1);
				OP_SIEVE_INIT: i_q <= BOUND_W'(2);
				OP_FINISH: built_q <= bound_q;
				OP_OUT_CHK: begin
					k_q <= '0;
					if (t_rdata.fac == 16'd0 && count_q < COUNT_W'(PRIME_LIST_DEPTH)) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
				OP_IN_WRN: k_q <= k_q + COUNT_W'(1);
				OP_IN_WRD, OP_NEXT_I: i_q <= i_q + BOUND_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_QUERY_START: qin_q <= ({1'b0, query_value} < built_q);
			OP_QUERY_LOAD: begin
				in_range <= qin_q;
				least_factor <= qin_q ? t_rdata.fac : '0;
				mobius <= qin_q ? t_rdata.mob : 2'sd0;
				totient <= qin_q ? t_rdata.tot : '0;
				least_exponent <= qin_q ? t_rdata.expo : '0;
				least_prime_power <= qin_q ? t_rdata.pp : '0;
				divisor_sum <= qin_q ? t_rdata.dsum : '0;
			end
			OP_OUT_CHK: ent_q <= (t_rdata.fac == 16'd0) ? prime_ent : t_rdata;
			OP_IN_U: u_q <= p_rdata;
			OP_IN_MUL: prod_q <= i_q[15:0] * u_q;
			OP_IN_M1: tot_q <= 16'(ent_q.tot * (div ? u_q : u_q - 16'd1));
			OP_IN_PP: pp_q <= 16'(ent_q.pp * u_q);
			OP_IN_DS: dsum_q <= 22'(t_rdata.dsum * pp_q);
			default: begin
			end
		endcase
	end

	always_comb begin
		st.out_free = !out_valid || out_ready;
		st.clear_last = (i_q == bound_q - BOUND_W'(1));
		st.i_end = (i_q >= bound_q);
		st.k_end = (k_q >= count_q);
		st.prod_ge = (prod_q >= {15'd0, bound_q});
		st.div = div;
	end
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the linear sieve engine: builds and table queries at several limits
module testbench import lsmt_pkg::*; ();

	typedef struct packed {
		logic kind;
		logic [15:0] value;
	} req_t;

	typedef struct packed {
		logic in_range;
		logic [15:0] least_factor;
		logic signed [1:0] mobius;
		logic [15:0] totient;
		logic [4:0] least_exponent;
		logic [15:0] least_prime_power;
		logic [21:0] divisor_sum;
	} entry_rec_t;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
	localparam int IDLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen;
	logic [15:0] cfg_wdata;

	lsmt_in_if items();
	lsmt_out_if results();

	linear_sieve_multiplicative_tables uut (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	// sieve tables kept by the predictor
	int unsigned lpf_tab[TABLE_DEPTH];
	int mu_tab[TABLE_DEPTH];
	int unsigned phi_tab[TABLE_DEPTH];
	int unsigned exp_tab[TABLE_DEPTH];
	int unsigned ppow_tab[TABLE_DEPTH];
	int unsigned sigma_tab[TABLE_DEPTH];
	int unsigned primes[$];
	int unsigned table_bound = 0;
	int unsigned limit_reg = LIMIT_RESET;

	req_t pending_reqs[$];
	entry_rec_t awaited_entries[$];
	int errors = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit hold_req = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void run_sieve();
		int unsigned bound;
		int unsigned m, u, pw, rest;
		bound = limit_reg + 10;
		if (bound > TABLE_DEPTH) bound = TABLE_DEPTH;
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			lpf_tab[j] = 0; mu_tab[j] = 0; phi_tab[j] = 0;
			exp_tab[j] = 0; ppow_tab[j] = 0; sigma_tab[j] = 0;
		end
		primes.delete();
		if (bound > 1) begin
			mu_tab[1] = 1; phi_tab[1] = 1; sigma_tab[1] = 1;
		end
		for (int unsigned i = 2; i < bound; i++) begin
			if (lpf_tab[i] == 0) begin
				lpf_tab[i] = i;
				if (primes.size() < PRIME_LIST_DEPTH) primes = {primes, i};
				mu_tab[i] = -1; phi_tab[i] = i - 1; exp_tab[i] = 1;
				ppow_tab[i] = i; sigma_tab[i] = i + 1;
			end
			foreach (primes[k]) begin
				u = primes[k];
				if (longint'(i) * u >= bound) break;
				m = i * u;
				lpf_tab[m] = u;
				if (i % u == 0) begin
					pw = ppow_tab[i];
					rest = (pw != 0) ? i / pw : i;
					mu_tab[m] = 0;
					phi_tab[m] = phi_tab[i] * u;
					exp_tab[m] = exp_tab[i] + 1;
					ppow_tab[m] = pw * u;
					sigma_tab[m] = sigma_tab[rest] * ppow_tab[m] + sigma_tab[i];
					break;
				end
				mu_tab[m] = -mu_tab[i];
				phi_tab[m] = phi_tab[i] * (u - 1);
				exp_tab[m] = 1;
				ppow_tab[m] = u;
				sigma_tab[m] = sigma_tab[i] * (u + 1);
			end
		end
		table_bound = bound;
	endfunction

	function automatic entry_rec_t lookup_entry(logic [15:0] q);
		entry_rec_t e;
		e = '0;
		if (q < table_bound) begin
			e.in_range = 1'b1;
			e.least_factor = lpf_tab[q][15:0];
			e.mobius = 2'(mu_tab[q]);
			e.totient = phi_tab[q][15:0];
			e.least_exponent = exp_tab[q][4:0];
			e.least_prime_power = ppow_tab[q][15:0];
			e.divisor_sum = sigma_tab[q][21:0];
		end
		return e;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (items.valid && items.ready) begin
				if (items.kind == KIND_BUILD) run_sieve();
				else awaited_entries = {awaited_entries, lookup_entry(items.query_value)};
			end
			if (!items.valid || items.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					items.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_t r;
					r = pending_reqs.pop_front();
					items.valid <= 1'b1;
					items.kind <= r.kind;
					items.query_value <= r.value;
					send_gap = gaps_on ? pick_gap() : 0;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (results.valid && results.ready) begin
				if (awaited_entries.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					entry_rec_t e;
					e = awaited_entries.pop_front();
					if (results.in_range !== e.in_range) begin
						$error("in_range exp %0d got %0d", e.in_range, results.in_range);
						errors++;
					end
					if (results.least_factor !== e.least_factor) begin
						$error("least_factor exp %0d got %0d", e.least_factor,
							results.least_factor);
						errors++;
					end
					if (results.mobius !== e.mobius) begin
						$error("mobius exp %0d got %0d", e.mobius, results.mobius);
						errors++;
					end
					if (results.totient !== e.totient) begin
						$error("totient exp %0d got %0d", e.totient, results.totient);
						errors++;
					end
					if (results.least_exponent !== e.least_exponent) begin
						$error("least_exponent exp %0d got %0d", e.least_exponent,
							results.least_exponent);
						errors++;
					end
					if (results.least_prime_power !== e.least_prime_power) begin
						$error("least_prime_power exp %0d got %0d", e.least_prime_power,
							results.least_prime_power);
						errors++;
					end
					if (results.divisor_sum !== e.divisor_sum) begin
						$error("divisor_sum exp %0d got %0d", e.divisor_sum,
							results.divisor_sum);
						errors++;
					end
				end
			end
			// long hold-off lets the engine back up and stall its input
			if (hold_req) begin
				hold_req = 1'b0;
				recv_stall = 300;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				results.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 99) < 30) begin
				recv_stall = pick_gap();
				results.ready <= (recv_stall == 0);
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic add_query(int unsigned v);
		req_t r;
		r.kind = KIND_QUERY;
		r.value = v[15:0];
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic add_build();
		req_t r;
		r.kind = KIND_BUILD;
		r.value = 16'($urandom);
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (items.valid || awaited_entries.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// config written only while the engine is idle
	task automatic set_limit(logic [15:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		limit_reg = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic random_phase(int n_items, logic [15:0] lim);
		int unsigned top;
		set_limit(lim);
		add_build();
		top = lim + 15;
		for (int j = 0; j < n_items; j++) begin
			if ($urandom_range(0, 99) < 2) add_build();
			else if ($urandom_range(0, 99) < 75) add_query($urandom_range(0, top));
			else add_query($urandom);
		end
		add_query($urandom_range(0, top));
	endtask

	initial begin
		items.valid = 1'b0;
		items.kind = 1'b0;
		items.query_value = '0;
		results.ready = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// queries before any build see nothing
		add_query(0); add_query(1); add_query(5); add_query(16'hFFFF);
		drain();

		// limit of zero still builds integers up to nine
		set_limit(16'd0);
		add_build();
		for (int v = 0; v <= 11; v++) add_query(v);
		add_query(16'hFFFF);
		drain();

		set_limit(16'd1);
		add_build();
		add_query(0); add_query(1); add_query(10); add_query(11); add_query(16'h8000);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			gaps_on = (ph % 4 != 1);
			stalls_on = (ph % 4 != 2);
			random_phase(125, (ph == 7) ? 16'd2000 : 16'($urandom_range(2, 300)));
			if (ph == 3) begin
				wait (pending_reqs.size() < 100);
				hold_req = 1'b1;
			end
			drain();
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;

		// largest limit: range clamps to the full table
		set_limit(16'hFFFF);
		add_build();
		add_query(16'hFFFF); add_query(16'hFFFE); add_query(65521); add_query(32768);
		add_query(59049); add_query(30030); add_query(65520); add_query(55440);
		for (int j = 0; j < 80; j++) add_query($urandom);
		drain();

		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/lsmt_pkg.sv
rtl/lsmt_in_if.sv
rtl/lsmt_out_if.sv
rtl/lsmt_ram.sv
rtl/lsmt_ctrl.sv
rtl/lsmt_dpath.sv
rtl/linear_sieve_multiplicative_tables.sv
tb/testbench.sv
